@@ sv/assert_macros.svh @@
// Assertion macros for the RTL of the duplicate message cache; included by its top level.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that prop holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that cond never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ sv/dmc_pkg.sv @@
// Types and constants of the duplicate message cache.
// No dependencies; imported by every module of the block.
`default_nettype none
package dmc_pkg;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_MARK  = 2'd1,
    OP_PRUNE = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_SUM1 = 2'd2,
    ST_SUM2 = 2'd3
  } state_e;

  localparam logic [31:0] WINDOW_RESET = 32'd30000;
  localparam int          PADDR_W      = 3;
  localparam logic        REG_WINDOW   = 1'b0;  // word index of window_ms

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  source_id;
    logic [7:0]  message_id;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic       is_duplicate;
    logic [4:0] pruned_count;
    logic [4:0] valid_count;
  } out_beat_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic        go;
    op_e         op;
    logic [7:0]  source_id;
    logic [7:0]  message_id;
    logic [31:0] now_ms;
    logic [31:0] window_ms;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ sv/dmc_cell.sv @@
// One cache entry: ids, timestamp, valid bit and the expire flag of the last command (set only by a prune).
// Depends on dmc_pkg.
`default_nettype none
module dmc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dmc_pkg::cell_cmd_t cmd_i,
  input  logic              wsel_i,
  input  logic              stop_i,
  output logic              stop_o,
  output logic              valid_o,
  output logic              kill_o
);
  import dmc_pkg::*;

  logic [7:0]  src_q;
  logic [7:0]  msg_q;
  logic [31:0] time_q;
  logic        valid_q, valid_d;
  logic        kill_q, kill_d;
  logic [31:0] age;
  logic        expired;
  logic        hit;
  logic        wr;

  assign age     = cmd_i.now_ms - time_q;
  assign expired = age > cmd_i.window_ms;
  assign hit     = valid_q && !expired &&
                   (src_q == cmd_i.source_id) && (msg_q == cmd_i.message_id);
  // Block every later cell once an unexpired match is seen.
  assign stop_o  = stop_i | hit;
  assign wr      = cmd_i.go && (cmd_i.op == OP_MARK) && wsel_i;

  always_comb begin
    valid_d = valid_q;
    kill_d  = kill_q;
    if (cmd_i.go) begin
      kill_d = 1'b0;
      unique case (cmd_i.op)
        OP_CHECK: valid_d = valid_q && !(expired && !stop_i);
        OP_MARK:  valid_d = valid_q | wsel_i;
        OP_PRUNE: begin
          kill_d  = valid_q && expired;
          valid_d = valid_q && !expired;
        end
        OP_CLEAR: valid_d = 1'b0;
        default:  valid_d = valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      kill_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      kill_q  <= kill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      src_q  <= cmd_i.source_id;
      msg_q  <= cmd_i.message_id;
      time_q <= cmd_i.now_ms;
    end
  end

  assign valid_o = valid_q;
  assign kill_o  = kill_q;

endmodule
`default_nettype wire

@@ sv/dmc_count.sv @@
// Population count over the flags of the cell row: registered group sums, then a total.
// Depends on dmc_pkg.
`default_nettype none
module dmc_count #(
  parameter int N  = 16,
  parameter int SW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [N-1:0]  bits_i,
  output logic [SW-1:0] sum_o
);
  import dmc_pkg::*;

  localparam int G = (N + 7) / 8;

  logic [G*8-1:0] pad;
  logic [3:0]     grp_d [G];
  logic [3:0]     grp_q [G];
  logic           rst_seen_q;

  assign pad = (G*8)'(bits_i);

  always_comb begin
    for (int g = 0; g < G; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < 8; j++) begin
        grp_d[g] = grp_d[g] + 4'(pad[g*8+j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < G; g++) begin
      grp_q[g] <= grp_d[g];
    end
  end

  // Force a zero total until the group sums have been loaded once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_seen_q <= 1'b0;
    end else begin
      rst_seen_q <= 1'b1;
    end
  end

  always_comb begin
    sum_o = '0;
    for (int g = 0; g < G; g++) begin
      sum_o = sum_o + SW'(grp_q[g]);
    end
    if (!rst_seen_q) begin
      sum_o = '0;
    end
  end

endmodule
`default_nettype wire

@@ sv/duplicate_message_cache.sv @@
// Top level of the duplicate message cache: sequencer, cell row, counters, APB register.
// Depends on dmc_pkg, dmc_cell, dmc_count and assert_macros.svh.
//
//   channel   signals                                   direction
//   in        in_valid_i, in_stall_o, in_data_i         item beat into the cache
//   out       out_valid_o, out_stall_i, out_data_o      result beat out of the cache
//   cfg       psel, penable, pwrite, paddr, pwdata,     APB register port (window_ms)
//             prdata, pready
//
// Every item passes through the accept state ST_IDLE, then ST_EVAL, in which all cells
// evaluate together and the stop chain ripples through the row, then ST_SUM1 and
// ST_SUM2 for the registered population count of valid and expired flags.
// Reset clears every valid bit, the write pointer and window_ms (to 30000)
// at once; no clearing pass is needed. A new item is taken while a result
// still waits in the output register; it then holds in ST_SUM2
// until the output register frees up.
`default_nettype none
`include "assert_macros.svh"
module duplicate_message_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  dmc_pkg::in_beat_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output dmc_pkg::out_beat_t       out_data_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [dmc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import dmc_pkg::*;

  localparam int PW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = (CW > 5) ? CW : 5;

  state_e      state_q, state_d;
  in_beat_t    cmd_q;
  logic [31:0] window_q;
  logic [PW-1:0] wp_q, wp_d;
  logic        dup_q;
  logic        out_valid_q;
  out_beat_t   out_q;

  logic        in_acc;
  logic        eval;
  logic        out_free;
  logic        out_load;
  cell_cmd_t   cell_cmd;

  logic [ENTRIES:0]   stop;
  logic [ENTRIES-1:0] valid_v;
  logic [ENTRIES-1:0] kill_v;
  logic [SW-1:0]      vcnt;
  logic [SW-1:0]      kcnt;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_WINDOW) ? window_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_WINDOW) begin
      window_q <= pwdata;
    end
  end

  // ---------------------------------------------------------- sequencer
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL: state_d = ST_SUM1;
      ST_SUM1: state_d = ST_SUM2;
      ST_SUM2: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    eval       = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_EVAL: eval       = 1'b1;
      ST_SUM1: ;
      ST_SUM2: out_load   = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted beat for the evaluate cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= in_data_i;
    end
  end

  // ---------------------------------------------------- write pointer
  always_comb begin
    wp_d = wp_q;
    if (eval) begin
      if (op_e'(cmd_q.opcode) == OP_MARK) begin
        wp_d = (wp_q == PW'(ENTRIES - 1)) ? '0 : wp_q + 1'b1;
      end else if (op_e'(cmd_q.opcode) == OP_CLEAR) begin
        wp_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else begin
      wp_q <= wp_d;
    end
  end

  // ---------------------------------------------------------- cell row
  assign cell_cmd.go         = eval;
  assign cell_cmd.op         = op_e'(cmd_q.opcode);
  assign cell_cmd.source_id  = cmd_q.source_id;
  assign cell_cmd.message_id = cmd_q.message_id;
  assign cell_cmd.now_ms     = cmd_q.now_ms;
  assign cell_cmd.window_ms  = window_q;

  // Stop enters clear at cell 0 and leaves the last cell as the duplicate flag.
  assign stop[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    dmc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cell_cmd),
      .wsel_i  (wp_q == PW'(i)),
      .stop_i  (stop[i]),
      .stop_o  (stop[i+1]),
      .valid_o (valid_v[i]),
      .kill_o  (kill_v[i])
    );
  end

  // Capture the duplicate flag; only a check can raise it.
  always_ff @(posedge clk_i) begin
    if (eval) begin
      dup_q <= (op_e'(cmd_q.opcode) == OP_CHECK) && stop[ENTRIES];
    end
  end

  // ------------------------------------------------------------ counts
  dmc_count #(.N(ENTRIES), .SW(SW)) u_vcount (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bits_i (valid_v),
    .sum_o  (vcnt)
  );

  dmc_count #(.N(ENTRIES), .SW(SW)) u_kcount (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bits_i (kill_v),
    .sum_o  (kcnt)
  );

  // ------------------------------------------------------ output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.is_duplicate <= dup_q;
      out_q.pruned_count <= kcnt[4:0];
      out_q.valid_count  <= vcnt[4:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // -------------------------------------------------------- assertions
  `ASSERT_CLK(a_result_after_three, in_acc |-> ##3 (state_q == ST_SUM2), "item did not reach the count stage in time")
  `ASSERT_NEVER(a_count_range, (state_q == ST_SUM2) && (vcnt > SW'(ENTRIES)), "valid count exceeds the entry count")
  `ASSERT_CLK(a_clear_wp, (eval && op_e'(cmd_q.opcode) == OP_CLEAR) |=> (wp_q == '0), "write pointer not reset by clear")
  `ASSERT_NEVER(a_kill_only_prune, (state_q == ST_SUM1) && (op_e'(cmd_q.opcode) != OP_PRUNE) && (kill_v != '0), "expire flags set outside a prune")

endmodule
`default_nettype wire
